/* rtl/bsr_pkg.sv */
// Package for the bounded splitmix random unit.
// Holds mixer constants, controller states and the command/status structs.
// No dependencies.
package bsr_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned CNT_W  = 7;

  localparam logic [DATA_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [DATA_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [DATA_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  localparam int unsigned SHIFT_1 = 30;
  localparam int unsigned SHIFT_2 = 27;
  localparam int unsigned SHIFT_3 = 31;

  // one remainder bit per cycle over the whole word
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DATA_W);

  // register index, taken from paddr[3]
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_THR,
    ST_DRAW,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_MIXB,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_TEST,
    ST_MOD,
    ST_DONE
  } state_t;

  // partial product of a 64x64 multiply, low 64 bits only
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_phase_t;

  typedef struct packed {
    logic       load_upper;
    logic       div_start_thr;
    logic       div_start_mod;
    logic       div_step;
    logic       limit_load;
    logic       draw;
    logic       mul_en;
    mul_phase_t mul_phase;
    logic       mul_sel_b;
    logic       mix_b;
    logic       res_zero;
    logic       res_rem;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic div_done;
    logic draw_ok;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bsr_ctrl.sv */
// Controller state machine of the bounded splitmix random unit.
// Depends on bsr_pkg for states and the command/status structs.
module bsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  bsr_pkg::sts_t sts,
  output bsr_pkg::cmd_t cmd,
  output bsr_pkg::state_t state
);

  bsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_phase = bsr_pkg::MUL_LL;
    s_tready   = 1'b0;
    unique case (state)
      bsr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_upper = 1'b1;
          state_next     = bsr_pkg::ST_BOUND;
        end
      end
      bsr_pkg::ST_BOUND: begin
        if (sts.trivial) begin
          cmd.res_zero = 1'b1;
          state_next   = bsr_pkg::ST_DONE;
        end else begin
          cmd.div_start_thr = 1'b1;
          state_next        = bsr_pkg::ST_THR;
        end
      end
      bsr_pkg::ST_THR: begin
        if (sts.div_done) begin
          cmd.limit_load = 1'b1;
          state_next     = bsr_pkg::ST_DRAW;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bsr_pkg::ST_DRAW: begin
        cmd.draw   = 1'b1;
        state_next = bsr_pkg::ST_MA0;
      end
      bsr_pkg::ST_MA0: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = bsr_pkg::MUL_LL;
        state_next    = bsr_pkg::ST_MA1;
      end
      bsr_pkg::ST_MA1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = bsr_pkg::MUL_HL;
        state_next    = bsr_pkg::ST_MA2;
      end
      bsr_pkg::ST_MA2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = bsr_pkg::MUL_LH;
        state_next    = bsr_pkg::ST_MIXB;
      end
      bsr_pkg::ST_MIXB: begin
        cmd.mix_b  = 1'b1;
        state_next = bsr_pkg::ST_MB0;
      end
      bsr_pkg::ST_MB0: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_b = 1'b1;
        cmd.mul_phase = bsr_pkg::MUL_LL;
        state_next    = bsr_pkg::ST_MB1;
      end
      bsr_pkg::ST_MB1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_b = 1'b1;
        cmd.mul_phase = bsr_pkg::MUL_HL;
        state_next    = bsr_pkg::ST_MB2;
      end
      bsr_pkg::ST_MB2: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_b = 1'b1;
        cmd.mul_phase = bsr_pkg::MUL_LH;
        state_next    = bsr_pkg::ST_TEST;
      end
      bsr_pkg::ST_TEST: begin
        if (sts.draw_ok) begin
          cmd.div_start_mod = 1'b1;
          state_next        = bsr_pkg::ST_MOD;
        end else begin
          state_next = bsr_pkg::ST_DRAW;
        end
      end
      bsr_pkg::ST_MOD: begin
        if (sts.div_done) begin
          cmd.res_rem = 1'b1;
          state_next  = bsr_pkg::ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bsr_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bsr_dp.sv */
// Datapath of the bounded splitmix random unit: generator state, mixer with
// shared 32x32 multiplier, serial remainder unit, seed register, output register.
// Depends on bsr_pkg for constants and the command/status structs.
module bsr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  bsr_pkg::cmd_t                cmd,
  output bsr_pkg::sts_t                sts,
  input  logic [bsr_pkg::DATA_W-1:0]   upper,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsr_pkg::DATA_W-1:0]   out_value,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [bsr_pkg::DATA_W-1:0]   cfg_wdata,
  output logic [bsr_pkg::DATA_W-1:0]   cfg_rdata
);

  localparam int unsigned W = bsr_pkg::DATA_W;
  localparam int unsigned H = bsr_pkg::HALF_W;
  localparam int unsigned C = bsr_pkg::CNT_W;

  logic [W-1:0] seed;
  logic [W-1:0] gen_state;
  logic [W-1:0] upper_q;
  logic [W-1:0] limit;
  logic [W-1:0] dq;
  logic [W-1:0] rem;
  logic [bsr_pkg::CNT_W-1:0] div_cnt;
  logic [W-1:0] mop;
  logic [W-1:0] acc;
  logic [W-1:0] res;

  logic [W-1:0] state_inc;
  logic [W-1:0] x_mix;
  logic [W:0]   trial;
  logic [W:0]   trial_sub;
  logic [W-1:0] mul_const;
  logic [H-1:0] mul_a;
  logic [H-1:0] mul_c;
  logic [W-1:0] prod;

  assign state_inc = gen_state + bsr_pkg::GOLDEN_INC;
  assign x_mix     = acc ^ (acc >> bsr_pkg::SHIFT_3);

  // restoring remainder step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem, dq[W-1]};
  assign trial_sub = trial - {1'b0, upper_q};

  assign mul_const = cmd.mul_sel_b ? bsr_pkg::MIX_MUL_B : bsr_pkg::MIX_MUL_A;

  always_comb begin
    mul_a = mop[H-1:0];
    mul_c = mul_const[H-1:0];
    case (cmd.mul_phase)
      bsr_pkg::MUL_LL: begin
        mul_a = mop[H-1:0];
        mul_c = mul_const[H-1:0];
      end
      bsr_pkg::MUL_HL: begin
        mul_a = mop[W-1:H];
        mul_c = mul_const[H-1:0];
      end
      bsr_pkg::MUL_LH: begin
        mul_a = mop[H-1:0];
        mul_c = mul_const[W-1:H];
      end
      default: begin
        mul_a = mop[H-1:0];
        mul_c = mul_const[H-1:0];
      end
    endcase
  end

  assign prod = W'(mul_a) * W'(mul_c);

  // seed and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      gen_state <= '0;
    end else if (cfg_we && (cfg_idx == bsr_pkg::REG_SEED)) begin
      seed      <= cfg_wdata;
      gen_state <= cfg_wdata;
    end else if (cmd.draw) begin
      gen_state <= state_inc;
    end
  end

  assign cfg_rdata = (cfg_idx == bsr_pkg::REG_SEED) ? seed : '0;

  // remainder unit
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start_thr || cmd.div_start_mod) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + C'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_upper) begin
      upper_q <= upper;
    end
    if (cmd.div_start_thr) begin
      dq  <= '0 - upper_q;
      rem <= '0;
    end else if (cmd.div_start_mod) begin
      dq  <= x_mix;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq <= {dq[W-2:0], 1'b0};
      if (!trial_sub[W]) begin
        rem <= trial_sub[W-1:0];
      end else begin
        rem <= trial[W-1:0];
      end
    end
    if (cmd.limit_load) begin
      limit <= rem;
    end
  end

  // mixer: xor-shift into the operand, then three partial products
  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      mop <= state_inc ^ (state_inc >> bsr_pkg::SHIFT_1);
    end else if (cmd.mix_b) begin
      mop <= acc ^ (acc >> bsr_pkg::SHIFT_2);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_phase == bsr_pkg::MUL_LL) begin
        acc <= prod;
      end else begin
        acc[W-1:H] <= acc[W-1:H] + prod[H-1:0];
      end
    end
  end

  // result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res <= '0;
    end else if (cmd.res_rem) begin
      res <= rem;
    end
    if (cmd.out_load) begin
      out_value <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.trivial  = (upper_q[W-1:1] == '0);
  assign sts.div_done = (div_cnt == bsr_pkg::DIV_STEPS);
  assign sts.draw_ok  = (x_mix >= limit);
  assign sts.out_free = !out_valid || out_ready;

endmodule

/* rtl/bounded_splitmix_random_unit.sv */
// Top level of the bounded splitmix random unit.
// Instantiates bsr_ctrl and bsr_dp; uses bsr_pkg for shared types.
//
// Returns one uniform value below the bound given in each input transfer,
// drawn from a splitmix64 sequence with rejection of draws under
// (2^64 - upper) mod upper. Items are handled one at a time. A bound of 0 or
// 1 returns 0 and leaves the generator state alone. For any other bound the
// serial remainder unit first reduces the threshold, one remainder bit per
// cycle; then the unit draws until a draw passes (a single draw more than half
// of the time; the mean number of draws is under 2), and the remainder unit
// reduces the passing draw the same way. Each draw goes through the mixer,
// whose two 64-bit multiplies are each three passes through one shared 32x32
// multiplier. The result sits in an output register, so a new item is taken
// while the previous result waits. Writing the seed register (address 0)
// reloads the generator state at once; only write it while the block is
// idle.
module bounded_splitmix_random_unit (
  input  logic                               clk,
  input  logic                               rst,
  // slave side: tdata = upper[63:0]
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bsr_pkg::DATA_W-1:0]         s_tdata,
  // master side: tdata = value[63:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bsr_pkg::DATA_W-1:0]         m_tdata,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsr_pkg::ADDR_W-1:0]         paddr,
  input  logic [bsr_pkg::DATA_W-1:0]         pwdata,
  output logic [bsr_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  bsr_pkg::cmd_t   cmd;
  bsr_pkg::sts_t   sts;
  bsr_pkg::state_t state;
  logic            cfg_we;

  // no wait states on the register port
  assign pready = 1'b1;
  // write lands on the access cycle
  assign cfg_we = psel && penable && pwrite && pready;

  bsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // registers sit every 8 bytes; paddr[3] picks the register
  bsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .upper     (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_idx   (paddr[3]),
    .cfg_wdata (pwdata),
    .cfg_rdata (prdata)
  );

  // after an accepted item, hold off new input until its result is loaded
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // never step the remainder unit past its last bit
  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sts.div_done)
    else $error("remainder unit stepped past completion");

  // a loaded result shows up on the master side next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result loaded but not presented");

  // generator advances only while working on an item
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.draw |-> (state != bsr_pkg::ST_IDLE) && !s_tready)
    else $error("draw issued while idle");

endmodule
